[hdl/psa_pkg.sv]
// Shared types, constants and luma weight table for the pixel saturation adjust unit.
// Used by psa_luma, pixel_saturation_adjust_unit, psa_checker and the testbench; depends on nothing else.
package psa_pkg;

  // pixel field format
  localparam int FIELD_W   = 21;
  localparam int FRAC_BITS = 16;
  localparam int TDATA_W   = 88;

  typedef logic signed [FIELD_W-1:0] field_t;

  localparam field_t FIELD_MAX = 21'sd1048575;
  localparam field_t FIELD_MIN = -21'sd1048576;

  // value of one, limited to the field range
  localparam int ONE_INT =
    ((64'd1 << FRAC_BITS) > 64'd1048575) ? 1048575 : (1 << FRAC_BITS);
  localparam field_t ONE_VAL = FIELD_W'(ONE_INT);

  // luma datapath widths
  localparam int WEIGHT_W  = 17;
  localparam int PROD_W    = 38;
  localparam int WSUM_W    = 40;
  localparam int LUMA_W    = 22;
  localparam int W_FRAC    = 16;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [LUMA_W-1:0]   luma_t;

  typedef struct packed {
    weight_t wr;
    weight_t wg;
    weight_t wb;
  } weights_t;

  // average mode: (sum + bias) / 3 - offset by reciprocal multiply, exact below 2^27
  localparam int AVG_SUM_W  = 24;
  localparam int AVG_SHIFT  = 27;
  localparam int AVG_RCP_W  = 26;
  localparam int AVG_PROD_W = AVG_SUM_W + AVG_RCP_W;
  localparam int AVG_Q_W    = AVG_PROD_W - AVG_SHIFT;
  localparam logic [AVG_SUM_W-1:0] AVG_BIAS   = 24'd6291457;
  localparam logic [AVG_RCP_W-1:0] AVG_RCP    = 26'd44739243;
  localparam logic signed [AVG_Q_W:0] AVG_OFFSET = 24'sd2097152;

  // channel gain datapath
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int DIFF_W    = 23;
  localparam int CPROD_W   = 40;
  localparam int RND_W     = CPROD_W - GAIN_FRAC;
  localparam int CSUM_W    = RND_W + 1;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN       = 3'd0,
    REG_LUMA_MODE  = 3'd1,
    REG_CLAMP_BLK  = 3'd2,
    REG_CLAMP_WHT  = 3'd3,
    REG_CHAN_EN    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    LUMA_REC709  = 3'd0,
    LUMA_REC2020 = 3'd1,
    LUMA_AP0     = 3'd2,
    LUMA_AP1     = 3'd3,
    LUMA_CCIR601 = 3'd4,
    LUMA_AVERAGE = 3'd5,
    LUMA_MAX     = 3'd6
  } luma_mode_t;

  // load enables of the two luma stages
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // Q.16 luma weights, unused selector falls back to rec709
  function automatic weights_t luma_weights(input logic [2:0] mode);
    weights_t w;
    unique case (mode)
      LUMA_REC2020: w = '{wr: 17'sd17216, wg: 17'sd44433, wb: 17'sd3886};
      LUMA_AP0:     w = '{wr: 17'sd22542, wg: 17'sd47721, wb: -17'sd4727};
      LUMA_AP1:     w = '{wr: 17'sd17841, wg: 17'sd44177, wb: 17'sd3519};
      LUMA_CCIR601: w = '{wr: 17'sd19589, wg: 17'sd38443, wb: 17'sd7504};
      default:      w = '{wr: 17'sd13933, wg: 17'sd46871, wb: 17'sd4732};
    endcase
    return w;
  endfunction

endpackage

[hdl/psa_luma.sv]
// Two-stage luminance unit: weighted sum, average of three, or maximum of R, G, B.
// Depends on psa_pkg for widths, weight table and mode codes.
module psa_luma (
  input  logic               clk,
  input  psa_pkg::stage_en_t en,
  input  logic [2:0]         luma_mode,
  input  psa_pkg::field_t    red,
  input  psa_pkg::field_t    green,
  input  psa_pkg::field_t    blue,
  output psa_pkg::luma_t     luma
);
  import psa_pkg::*;

  weights_t                     w;
  logic signed [PROD_W-1:0]     prod_r_c;
  logic signed [PROD_W-1:0]     prod_g_c;
  logic signed [PROD_W-1:0]     prod_b_c;
  logic signed [AVG_SUM_W:0]    sum_c;
  field_t                       max_rg_c;
  field_t                       max_c;

  logic signed [PROD_W-1:0]     prod_r;
  logic signed [PROD_W-1:0]     prod_g;
  logic signed [PROD_W-1:0]     prod_b;
  logic [AVG_SUM_W-1:0]         avg_sum;
  field_t                       max_val;

  logic signed [WSUM_W-1:0]     wsum_c;
  logic signed [WSUM_W-1:0]     wshift_c;
  logic [AVG_PROD_W-1:0]        avg_prod_c;
  logic signed [AVG_Q_W:0]      avg_c;
  luma_t                        luma_next;

  // stage 1: weight products, biased sum and maximum
  always_comb begin
    w        = luma_weights(luma_mode);
    prod_r_c = PROD_W'(w.wr) * PROD_W'(red);
    prod_g_c = PROD_W'(w.wg) * PROD_W'(green);
    prod_b_c = PROD_W'(w.wb) * PROD_W'(blue);
    sum_c    = (AVG_SUM_W+1)'(red) + (AVG_SUM_W+1)'(green) + (AVG_SUM_W+1)'(blue)
             + $signed({1'b0, AVG_BIAS});
    max_rg_c = (red > green) ? red : green;
    max_c    = (max_rg_c > blue) ? max_rg_c : blue;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r  <= prod_r_c;
      prod_g  <= prod_g_c;
      prod_b  <= prod_b_c;
      avg_sum <= sum_c[AVG_SUM_W-1:0];
      max_val <= max_c;
    end
  end

  // stage 2: rounding of the weighted sum, divide by three, mode select
  always_comb begin
    wsum_c     = WSUM_W'(prod_r) + WSUM_W'(prod_g) + WSUM_W'(prod_b)
               + WSUM_W'(1 << (W_FRAC - 1));
    wshift_c   = wsum_c >>> W_FRAC;
    avg_prod_c = AVG_PROD_W'(avg_sum) * AVG_PROD_W'(AVG_RCP);
    avg_c      = $signed({1'b0, avg_prod_c[AVG_PROD_W-1:AVG_SHIFT]}) - AVG_OFFSET;
    case (luma_mode)
      LUMA_AVERAGE: luma_next = LUMA_W'(avg_c);
      LUMA_MAX:     luma_next = LUMA_W'(max_val);
      default:      luma_next = wshift_c[LUMA_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      luma <= luma_next;
    end
  end

endmodule

[hdl/pixel_saturation_adjust_unit.sv]
// Top level of the pixel saturation adjust unit: stream ports, config registers,
// valid/ready pipeline control and the per-channel gain stages; uses psa_pkg, psa_luma.
//
// Usage:
//   s_* is the pixel input stream, m_* the adjusted pixel output stream. A
//   transaction happens at a rising edge with tvalid and tready both high.
//   tdata carries red, green, blue, alpha (signed Q4.16, 21 bits each) from
//   bit 0 upward, padded with zeros to 88 bits.
//   The cfg_* channel writes one register per transaction; cfg_ready is always
//   high. Index 0 gain, 1 luma mode, 2 black clamp, 3 white clamp, 4 channel
//   enables; other indexes are ignored. Write registers only while idle.
// Timing:
//   Four register stages (products, luma, gain multiply, output). An accepted
//   pixel passes through them in order to m_tdata with m_tvalid, and one pixel
//   per clock is sustained while m_tready is high; the stage depth is set by the
//   17x21 weight and 17x23 gain multipliers, each followed by a register.
// Reset and stalls:
//   rst (synchronous) empties the pipeline and loads the register defaults.
//   When m_tready is low, stages fill up behind the held output; s_tready
//   drops only once every stage holds a pixel, and nothing is lost or repeated.
module pixel_saturation_adjust_unit (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [psa_pkg::TDATA_W-1:0]         s_tdata,   // red_in, green_in, blue_in, alpha_in
  // pixel output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [psa_pkg::TDATA_W-1:0]         m_tdata,   // red_out, green_out, blue_out, alpha_out
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [psa_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psa_pkg::*;

  localparam int NCH = 4;
  localparam int NCOL = 3;
  localparam int PAD_W = TDATA_W - NCH * FIELD_W;

  // configuration registers
  logic [GAIN_W-1:0] saturation_gain;
  logic [2:0]        luma_mode;
  logic              clamp_black;
  logic              clamp_white;
  logic [NCH-1:0]    channel_enable;

  // pipeline control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  stage_en_t luma_en;

  // pipeline payload
  field_t pix_in [NCH];
  field_t pix1   [NCH];
  field_t pix2   [NCH];
  field_t pix3   [NCH];
  field_t res    [NCH];
  field_t res_next [NCH];
  luma_t  luma2;
  luma_t  luma3;
  logic signed [CPROD_W-1:0] cprod3 [NCOL];
  logic signed [CPROD_W-1:0] cprod_next [NCOL];
  logic signed [GAIN_W:0]    gain_s;

  // register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation_gain <= 16'd4096;
      luma_mode       <= LUMA_REC709;
      clamp_black     <= 1'b1;
      clamp_white     <= 1'b0;
      channel_enable  <= 4'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN:      saturation_gain <= cfg_data[GAIN_W-1:0];
        REG_LUMA_MODE: luma_mode       <= cfg_data[2:0];
        REG_CLAMP_BLK: clamp_black     <= cfg_data[0];
        REG_CLAMP_WHT: clamp_white     <= cfg_data[0];
        REG_CHAN_EN:   channel_enable  <= cfg_data[NCH-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain, a stage loads when it is empty or its successor moves
  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v4;

  assign luma_en.s1 = rdy1 && s_tvalid;
  assign luma_en.s2 = rdy2 && v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // unpack input fields
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      pix_in[i] = s_tdata[i*FIELD_W +: FIELD_W];
    end
  end

  // luminance, two stages in step with pix1 and pix2
  psa_luma u_luma (
    .clk       (clk),
    .en        (luma_en),
    .luma_mode (luma_mode),
    .red       (pix_in[0]),
    .green     (pix_in[1]),
    .blue      (pix_in[2]),
    .luma      (luma2)
  );

  // pixel delay through the luma stages
  always_ff @(posedge clk) begin
    if (luma_en.s1) pix1 <= pix_in;
    if (luma_en.s2) pix2 <= pix1;
  end

  // stage 3: gain times distance from luma
  assign gain_s = $signed({1'b0, saturation_gain});

  always_comb begin
    for (int i = 0; i < NCOL; i++) begin
      cprod_next[i] = CPROD_W'(gain_s) * CPROD_W'(DIFF_W'(pix2[i]) - DIFF_W'(luma2));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      pix3   <= pix2;
      luma3  <= luma2;
      cprod3 <= cprod_next;
    end
  end

  // saturate a sum to the field range
  function automatic field_t sat_field(input logic signed [CSUM_W-1:0] v);
    if (v > CSUM_W'(FIELD_MAX)) begin
      return FIELD_MAX;
    end else if (v < CSUM_W'(FIELD_MIN)) begin
      return FIELD_MIN;
    end
    return v[FIELD_W-1:0];
  endfunction

  // optional black and white clamps
  function automatic field_t clamp_val(input field_t v, input logic cb, input logic cw);
    field_t r;
    r = v;
    if (cb && r < 0) r = '0;
    if (cw && r > ONE_VAL) r = ONE_VAL;
    return r;
  endfunction

  // stage 4: round, add luma back, saturate, clamp, bypass disabled channels
  always_comb begin
    logic signed [CPROD_W-1:0] rnd;
    logic signed [CSUM_W-1:0]  sum;
    for (int i = 0; i < NCOL; i++) begin
      rnd = (cprod3[i] + CPROD_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      sum = CSUM_W'($signed(rnd[RND_W-1:0])) + CSUM_W'(luma3);
      res_next[i] = channel_enable[i]
                  ? clamp_val(sat_field(sum), clamp_black, clamp_white)
                  : pix3[i];
    end
    res_next[NCOL] = channel_enable[NCOL]
                   ? clamp_val(pix3[NCOL], clamp_black, clamp_white)
                   : pix3[NCOL];
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) res <= res_next;
  end

  // pack output fields
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < NCH; i++) begin
      m_tdata[i*FIELD_W +: FIELD_W] = res[i];
    end
    m_tdata[TDATA_W-1 -: PAD_W] = '0;
  end

  // an idle output stage lets the whole chain move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready while output stage is empty");

  // a stalled first stage keeps its pixel
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> v1)
    else $error("first stage dropped a pixel during a stall");

  // reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

endmodule

[sim/psa_checker.sv]
`timescale 1ns / 100ps
// Checker for the pixel saturation adjust unit: tracks register writes, predicts
// each adjusted pixel and compares it with the output stream; depends on psa_pkg.
module psa_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [psa_pkg::TDATA_W-1:0]     s_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [psa_pkg::TDATA_W-1:0]     m_tdata,   // red_out, green_out, blue_out, alpha_out
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [psa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              pixels_in_flight
);
  import psa_pkg::*;

  // four channels, red in the lowest bits
  typedef logic [3:0][FIELD_W-1:0] rgba_t;

  // shadow copy of the register file
  logic [15:0] gain_q412;
  logic [2:0]  luma_sel;
  logic        clamp_blk;
  logic        clamp_wht;
  logic [3:0]  chan_en;

  rgba_t adjusted_px_q[$];
  string chan_name [4] = '{"red", "green", "blue", "alpha"};

  // luminance of one pixel under the current mode
  function automatic longint luma_of(longint r, longint g, longint b);
    longint wr, wg, wb, hi;
    wr = 13933;
    wg = 46871;
    wb = 4732;
    case (luma_sel)
      LUMA_AVERAGE: return (r + g + b + 64'sd6291457) / 3 - 64'sd2097152;
      LUMA_MAX: begin
        hi = (r > g) ? r : g;
        return (hi > b) ? hi : b;
      end
      LUMA_REC2020: begin
        wr = 17216; wg = 44433; wb = 3886;
      end
      LUMA_AP0: begin
        wr = 22542; wg = 47721; wb = -4727;
      end
      LUMA_AP1: begin
        wr = 17841; wg = 44177; wb = 3519;
      end
      LUMA_CCIR601: begin
        wr = 19589; wg = 38443; wb = 7504;
      end
      default: ;  // rec709, also for the unused selector
    endcase
    return (wr * r + wg * g + wb * b + 64'sd32768) >>> W_FRAC;
  endfunction

  // optional black and white clamps of an enabled channel
  function automatic longint clamp_unit(longint v);
    if (clamp_blk && v < 0) v = 0;
    if (clamp_wht && v > ONE_INT) v = ONE_INT;
    return v;
  endfunction

  // expected output pixel for one input pixel
  function automatic rgba_t adjust_pixel(rgba_t px);
    longint c [4];
    longint luma, gl, v;
    field_t f;
    rgba_t res;
    for (int k = 0; k < 4; k++) begin
      f = px[k];
      c[k] = f;
    end
    luma = luma_of(c[0], c[1], c[2]);
    gl = gain_q412;
    for (int k = 0; k < 3; k++) begin
      if (chan_en[k]) begin
        v = luma + ((gl * (c[k] - luma) + 64'sd2048) >>> GAIN_FRAC);
        if (v > FIELD_MAX) v = FIELD_MAX;
        if (v < FIELD_MIN) v = FIELD_MIN;
        c[k] = clamp_unit(v);
      end
    end
    if (chan_en[3]) c[3] = clamp_unit(c[3]);
    for (int k = 0; k < 4; k++) res[k] = FIELD_W'(c[k]);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t psa_checker: %s", $time, msg);
    mismatch_count++;
  endtask

  // watch all four channels at each edge
  always @(posedge clk) begin : watch
    rgba_t got, want;
    field_t exp_f, got_f;
    if (rst) begin
      gain_q412 = 16'd4096;
      luma_sel  = LUMA_REC709;
      clamp_blk = 1'b1;
      clamp_wht = 1'b0;
      chan_en   = 4'd7;
      adjusted_px_q.delete();
      mismatch_count = 0;
      pixels_in_flight <= 0;
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:      gain_q412 = cfg_data;
          REG_LUMA_MODE: luma_sel  = cfg_data[2:0];
          REG_CLAMP_BLK: clamp_blk = cfg_data[0];
          REG_CLAMP_WHT: clamp_wht = cfg_data[0];
          REG_CHAN_EN:   chan_en   = cfg_data[3:0];
          default: ;
        endcase
      end
      // input transaction
      if (s_tvalid && s_tready)
        adjusted_px_q.push_back(adjust_pixel(s_tdata[4*FIELD_W-1:0]));
      // output transaction
      if (m_tvalid && m_tready) begin
        got = m_tdata[4*FIELD_W-1:0];
        if (adjusted_px_q.size() == 0) begin
          report_mismatch($sformatf("output pixel 0x%0h with no pixel outstanding", got));
        end else begin
          want = adjusted_px_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            exp_f = want[k];
            got_f = got[k];
            if (got_f !== exp_f)
              report_mismatch($sformatf("%s expected %0d got %0d",
                                        chan_name[k], exp_f, got_f));
          end
          if (m_tdata[TDATA_W-1:4*FIELD_W] !== '0)
            report_mismatch("nonzero padding bits in output tdata");
        end
      end
      pixels_in_flight <= adjusted_px_q.size();
    end
  end

endmodule

[sim/tb_pixel_saturation_adjust_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the pixel saturation adjust unit: clock, reset, pixel and
// register stimulus, random output back-pressure and verdict; uses psa_pkg, psa_checker.
module tb_pixel_saturation_adjust_unit;
  import psa_pkg::*;

  localparam int RAND_PHASES    = 12;
  localparam int PHASE_PIXELS   = 125;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT     = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd5;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata = '0;   // red_in, green_in, blue_in, alpha_in
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_W-1:0]     m_tdata;        // red_out, green_out, blue_out, alpha_out
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatch_count;
  int pixels_in_flight;
  int hold_off_asked = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  always #5 clk = ~clk;

  pixel_saturation_adjust_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  psa_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pixels_in_flight(pixels_in_flight)
  );

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // pixel component: extremes, values near the unit range, or any bit pattern
  function automatic field_t rand_field();
    case ($urandom_range(0, 9)) inside
      0: begin
        case ($urandom_range(0, 4))
          0: return FIELD_MAX;
          1: return FIELD_MIN;
          2: return '0;
          3: return ONE_VAL;
          default: return -21'sd1;
        endcase
      end
      [1:5]: return field_t'($urandom_range(0, 72000)) - 21'sd4000;
      default: return field_t'($urandom);
    endcase
  endfunction

  // one pixel transaction, then an optional gap
  task automatic send_pixel(input field_t r, input field_t g, input field_t b,
                            input field_t a);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({a, b, g, r});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = tx_idle ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering pixels and wait until every result is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight != 0) @(posedge clk);
  endtask

  // register write transaction, valid is left high for back-to-back writes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full register set, with junk in the unused upper data bits
  task automatic load_config(input logic [15:0] gain, input logic [2:0] mode,
                             input logic blk, input logic wht, input logic [3:0] en);
    write_reg(REG_GAIN, gain);
    write_reg(REG_LUMA_MODE, {13'($urandom), mode});
    write_reg(REG_CLAMP_BLK, {15'($urandom), blk});
    write_reg(REG_CLAMP_WHT, {15'($urandom), wht});
    write_reg(REG_CHAN_EN, {12'($urandom), en});
    cfg_valid <= 1'b0;
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin : pixel_sink
    int served;
    int stall;
    served = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_asked != served) begin
        served++;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        stall = idle_len();
        if (stall == 0) stall = 1;
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // end the run when nothing has been accepted for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("pixel_saturation_adjust_unit regression: fail");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [15:0] gain;
    logic [2:0]  mode;
    logic [3:0]  en;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: rec709, unity gain, black clamp, colour channels only
    send_pixel('0, '0, '0, '0);
    send_pixel(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_pixel(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN);
    send_pixel(ONE_VAL, ONE_VAL, ONE_VAL, ONE_VAL);
    send_pixel(FIELD_MAX, FIELD_MIN, '0, ONE_VAL);
    send_pixel(FIELD_MIN, FIELD_MAX, ONE_VAL, -21'sd1);
    send_pixel(-21'sd1, 21'sd1, 21'sd32768, FIELD_MAX);

    // zero gain gives grey, unused luma selector, ignored index, all channels
    wait_idle();
    write_reg(REG_UNUSED, 16'($urandom));
    load_config(16'd0, 3'd7, 1'b0, 1'b1, 4'hF);
    send_pixel(ONE_VAL, '0, '0, FIELD_MIN);
    send_pixel('0, ONE_VAL, '0, FIELD_MAX);
    send_pixel(FIELD_MAX, FIELD_MIN, FIELD_MAX, ONE_VAL + 21'sd1);
    send_pixel(21'sd70000, -21'sd5, 21'sd300, -21'sd70000);
    send_pixel(FIELD_MIN, FIELD_MAX, FIELD_MIN, '0);
    send_pixel(ONE_VAL, ONE_VAL, ONE_VAL, ONE_VAL);

    // ap1 weights with the largest gain and no clamps
    wait_idle();
    load_config(16'hFFFF, LUMA_AP1, 1'b0, 1'b0, 4'b1010);
    send_pixel(ONE_VAL, '0, '0, ONE_VAL);
    send_pixel('0, ONE_VAL, '0, '0);
    send_pixel('0, '0, ONE_VAL, '0);
    send_pixel(FIELD_MAX, '0, FIELD_MIN, FIELD_MAX);
    send_pixel(21'sd1000, -21'sd1000, 21'sd500, -21'sd1);
    send_pixel(FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX);

    // ap0 has a negative blue weight
    wait_idle();
    load_config(16'd8192, LUMA_AP0, 1'b1, 1'b1, 4'd7);
    send_pixel('0, '0, FIELD_MAX, '0);
    send_pixel(FIELD_MAX, FIELD_MAX, FIELD_MIN, '0);
    send_pixel(ONE_VAL, ONE_VAL, '0, '0);
    send_pixel(21'sd32768, 21'sd16384, 21'sd65535, -21'sd2);

    // random phases, each with its own register settings and idle pattern
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      tx_idle <= (p % 3 != 0) && (p != PRESSURE_PHASE);
      rx_idle <= (p % 4 != 1);
      case ($urandom_range(0, 5))
        0: gain = 16'd0;
        1: gain = 16'd4096;
        2: gain = 16'hFFFF;
        3: gain = 16'($urandom);
        default: gain = 16'($urandom_range(2048, 8192));
      endcase
      mode = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      en = (p == 1) ? 4'd0 : (p == 2) ? 4'hF : 4'($urandom);
      load_config(gain, mode, 1'($urandom), 1'($urandom), en);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // long output hold-off while pixels keep coming
        if (p == PRESSURE_PHASE && n == 20) hold_off_asked <= hold_off_asked + 1;
        send_pixel(rand_field(), rand_field(), rand_field(), rand_field());
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("pixel_saturation_adjust_unit regression: pass");
    else
      $display("pixel_saturation_adjust_unit regression: fail");
    $finish;
  end

endmodule
